// File: hw/rtl/aks_pkg.sv
// Shared types, constants and byte functions for the AES-128 key schedule.
`default_nettype none
package aks_pkg;

    localparam int BYTES_PER_KEY = 16;
    localparam logic [3:0] NUM_ROUNDS = 4'd10;
    localparam logic [3:0] LAST_BYTE = 4'(BYTES_PER_KEY - 1);

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
    } key_word_t;

    typedef struct packed {
        logic [3:0]  round_number;
        logic [63:0] round_key_high;
        logic [63:0] round_key_low;
        logic        final_key;
    } round_key_t;

    // sequencer -> byte engine / output stage
    typedef struct packed {
        logic       load;
        logic       shift;
        logic       copy;
        logic [3:0] byte_idx;
        logic [3:0] round;
    } aks_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // round constant, top byte only
    function automatic logic [7:0] rcon(input logic [3:0] round);
        logic [7:0] rc;
        case (round)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aks_engine.sv
// Byte-serial round key engine: 16-byte shift register, one key byte per cycle while shift is set.
`default_nettype none
module aks_engine (
    input  wire              aclk,
    input  aks_pkg::key_word_t key_in,
    input  aks_pkg::aks_ctl_t  ctl,
    output logic [127:0]     round_key
);
    import aks_pkg::*;

    logic [7:0]   sr_reg  [BYTES_PER_KEY];
    logic [7:0]   sr_next [BYTES_PER_KEY];
    logic [127:0] key_flat;
    logic [7:0]   sub_in;
    logic [7:0]   sub_out;
    logic [7:0]   mix_byte;
    logic [7:0]   new_byte;

    // Byte j of the new key = old[j] ^ t. For the first word t comes from
    // RotWord/SubWord of old word 3 (taps 13 and 9 as the register shifts);
    // after that t is new[j-4], which sits at tap 12.
    always_comb begin
        key_flat = {key_in.key_high, key_in.key_low};
        sub_in   = (ctl.byte_idx[1:0] == 2'd3) ? sr_reg[9] : sr_reg[13];
        sub_out  = sbox(sub_in);
        if (ctl.byte_idx[3:2] == 2'b00) begin
            mix_byte = sub_out ^ ((ctl.byte_idx[1:0] == 2'd0) ? rcon(ctl.round) : 8'h00);
        end else begin
            mix_byte = sr_reg[12];
        end
        new_byte = sr_reg[0] ^ mix_byte;
    end

    always_comb begin
        for (int k = 0; k < BYTES_PER_KEY; k++) begin
            sr_next[k] = sr_reg[k];
        end
        if (ctl.load) begin
            for (int k = 0; k < BYTES_PER_KEY; k++) begin
                sr_next[k] = key_flat[127 - 8 * k -: 8];
            end
        end else if (ctl.shift) begin
            for (int k = 0; k < BYTES_PER_KEY - 1; k++) begin
                sr_next[k] = sr_reg[k + 1];
            end
            sr_next[BYTES_PER_KEY - 1] = new_byte;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < BYTES_PER_KEY; k++) begin
            sr_reg[k] <= sr_next[k];
        end
    end

    always_comb begin
        for (int k = 0; k < BYTES_PER_KEY; k++) begin
            round_key[127 - 8 * k -: 8] = sr_reg[k];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/aks_seq.sv
// Sequencer: round and byte counters that drive the engine and the output stage.
`default_nettype none
module aks_seq (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire              out_free,
    output aks_pkg::aks_ctl_t ctl
);
    import aks_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HOLD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [3:0] round_reg, round_next;
    logic [3:0] byte_reg,  byte_next;

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        byte_next    = byte_reg;
        ctl.load     = 1'b0;
        ctl.shift    = 1'b0;
        ctl.copy     = 1'b0;
        ctl.byte_idx = byte_reg;
        ctl.round    = round_reg;
        s_ready      = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    round_next = 4'd0;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    ctl.copy = 1'b1;
                    if (round_reg == NUM_ROUNDS) begin
                        state_next = ST_IDLE;
                    end else begin
                        round_next = round_reg + 4'd1;
                        byte_next  = 4'd0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                ctl.shift = 1'b1;
                byte_next = byte_reg + 4'd1;
                if (byte_reg == LAST_BYTE) begin
                    state_next = ST_HOLD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= 4'd0;
            byte_reg  <= 4'd0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            byte_reg  <= byte_next;
        end
    end

    a_run_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (round_reg != 4'd0 && round_reg <= NUM_ROUNDS))
        else $error("engine running with round out of range");
    a_last_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && byte_reg == LAST_BYTE) |=> (state_reg == ST_HOLD))
        else $error("round did not finish after last byte");
    a_idle_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && out_free && round_reg == NUM_ROUNDS) |=> s_ready)
        else $error("not idle after final round key");

endmodule
`default_nettype wire

// File: hw/rtl/aes128_key_schedule_top.sv
// Top level of the byte-serial AES-128 key schedule with registered output.
//
//  channel  dir  ports                    word
//  -------  ---  -----------------------  ----------------------------------
//  s_       in   s_valid s_ready s_data   key_word_t: 128-bit cipher key
//  m_       out  m_valid m_ready m_data   round_key_t: one of 11 round keys
//
// A key is taken only while the engine is idle; round key 0 (the key itself)
// is loaded into the engine and then copied to the output register. Each
// further round key is built by the byte engine from its 16 bytes, one key
// byte per cycle through the shift register and one S-box, and then copied
// to the output register. A stalled m_ready parks the finished round key in
// the engine until the output register frees up. The next key is accepted
// as soon as round key 10 sits in the output register. Reset clears control
// and m_valid only.
`default_nettype none
module aes128_key_schedule_top (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  aks_pkg::key_word_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output aks_pkg::round_key_t m_data
);
    import aks_pkg::*;

    aks_ctl_t     ctl;
    logic [127:0] round_key;
    logic         out_free;
    logic         m_valid_reg, m_valid_next;
    round_key_t   m_data_reg,  m_data_next;

    assign out_free = !m_valid_reg || m_ready;

    aks_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .ctl      (ctl)
    );

    aks_engine u_engine (
        .aclk      (aclk),
        .key_in    (s_data),
        .ctl       (ctl),
        .round_key (round_key)
    );

    // output register: loaded on copy, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (ctl.copy) begin
            m_valid_next              = 1'b1;
            m_data_next.round_number  = ctl.round;
            m_data_next.round_key_high = round_key[127:64];
            m_data_next.round_key_low  = round_key[63:0];
            m_data_next.final_key     = (ctl.round == NUM_ROUNDS);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("key accepted while schedule still running");
    a_final_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.final_key) |-> (m_data.round_number == NUM_ROUNDS))
        else $error("final flag on wrong round");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.copy && m_valid_reg && !m_ready))
        else $error("round key overwrote an untaken word");
    a_shift_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.shift |-> !s_ready)
        else $error("input ready while engine shifting");

endmodule
`default_nettype wire
